// ----- hw/rtl/sorted_store_range_count_macros.svh -----
// Assertion macros used by the sorted store RTL.
// Depends on a clk and an active-low rst_n in the scope of each use.
`ifndef SORTED_STORE_RANGE_COUNT_MACROS_SVH
`define SORTED_STORE_RANGE_COUNT_MACROS_SVH

// same-cycle implication
`define SSRC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SSRC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/ssrc_pkg.sv -----
// Types and constants of the sorted store with range count.
// No dependencies.
`timescale 1ns / 1ps

package ssrc_pkg;

    localparam int DATA_W  = 32;
    localparam int COUNT_W = 7;

    typedef enum logic [1:0] {
        ACT_CLEAR = 2'd0,
        ACT_LOAD  = 2'd1,
        ACT_QUERY = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    typedef struct packed {
        logic [1:0]               action;
        logic signed [DATA_W-1:0] load_value;
        logic signed [DATA_W-1:0] bound_a;
        logic signed [DATA_W-1:0] bound_b;
    } req_t;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic               rejected;
    } rsp_t;

    // per-beat controls broadcast to every cell
    typedef struct packed {
        logic ins;
        logic cap;
    } cell_ctl_t;

endpackage

// ----- hw/rtl/sorted_store_range_count.sv -----
// Sorted store with inclusive range count: top level, control and result buffering.
// Depends on ssrc_pkg, ssrc_cell, ssrc_thermo and the assertion macro header.
`timescale 1ns / 1ps

// Keeps up to DEPTH signed 32-bit values in ascending order in a row of cells.
// A clear beat empties the store; on a load beat every cell decides at once whether
// to hold, take the new value or take its left neighbor's entry. On a query beat the
// cells register their bound compares, then in the compare state the two flag
// thermometers are encoded and subtracted. Results pass through a pending stage
// and an output register, so a new beat is taken while one result waits, but not
// while both hold one. One request produces exactly one response; a load into a
// full store is dropped and flagged. Count wraps to 7 bits when DEPTH exceeds 127.
module sorted_store_range_count #(
    parameter int DEPTH = 64
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  ssrc_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output ssrc_pkg::rsp_t rsp
);
    import ssrc_pkg::*;
    `include "sorted_store_range_count_macros.svh"

    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic {
        S_IDLE,
        S_CMP
    } state_t;

    state_t          state_reg;
    logic [CW-1:0]   occ_reg;
    logic            pend_reg;
    rsp_t            pend_data_reg;
    logic            rsp_valid_reg;
    rsp_t            rsp_data_reg;

    logic            acc;
    logic            out_load;
    logic            full;
    logic            a_lt_b;
    logic signed [DATA_W-1:0] bnd_a;
    logic signed [DATA_W-1:0] bnd_b;
    logic signed [DATA_W-1:0] hi;
    logic signed [DATA_W-1:0] lo;
    logic signed [DATA_W-1:0] key;
    cell_ctl_t       ctl;

    logic signed [DATA_W-1:0] cell_value [DEPTH];
    logic [DEPTH-1:0] cell_gt;
    logic [DEPTH-1:0] le_therm;
    logic [DEPTH-1:0] lt_therm;
    logic [CW-1:0]    le_cnt;
    logic [CW-1:0]    lt_cnt;
    logic [CW-1:0]    range_cnt;
    logic [CW-1:0]    occ_next;

    assign out_load  = pend_reg && (!rsp_valid_reg || rsp_ready);
    assign req_ready = (state_reg == S_IDLE) && (!pend_reg || out_load);
    assign acc       = req_valid && req_ready;
    assign full      = occ_reg == CW'(DEPTH);

    assign bnd_a  = req.bound_a;
    assign bnd_b  = req.bound_b;
    assign a_lt_b = bnd_a < bnd_b;
    assign lo     = a_lt_b ? bnd_a : bnd_b;
    assign hi     = a_lt_b ? bnd_b : bnd_a;
    assign key    = (req.action == ACT_LOAD) ? req.load_value : hi;

    assign ctl.ins = acc && (req.action == ACT_LOAD) && !full;
    assign ctl.cap = acc && (req.action == ACT_QUERY);

    generate
        for (genvar i = 0; i < DEPTH; i++)
        begin : g_cell
            if (i == 0)
            begin : g_head
                ssrc_cell #(.IDX(i), .CW(CW)) u_cell (
                    .clk        (clk),
                    .ctl        (ctl),
                    .occ        (occ_reg),
                    .key        (key),
                    .lo         (lo),
                    .left_value (key),
                    .left_gt    (1'b0),
                    .value      (cell_value[i]),
                    .gt         (cell_gt[i]),
                    .le_flag    (le_therm[i]),
                    .lt_flag    (lt_therm[i])
                );
            end
            else
            begin : g_body
                ssrc_cell #(.IDX(i), .CW(CW)) u_cell (
                    .clk        (clk),
                    .ctl        (ctl),
                    .occ        (occ_reg),
                    .key        (key),
                    .lo         (lo),
                    .left_value (cell_value[i-1]),
                    .left_gt    (cell_gt[i-1]),
                    .value      (cell_value[i]),
                    .gt         (cell_gt[i]),
                    .le_flag    (le_therm[i]),
                    .lt_flag    (lt_therm[i])
                );
            end
        end
    endgenerate

    ssrc_thermo #(.N(DEPTH), .CW(CW)) u_le_enc (
        .therm (le_therm),
        .cnt   (le_cnt)
    );

    ssrc_thermo #(.N(DEPTH), .CW(CW)) u_lt_enc (
        .therm (lt_therm),
        .cnt   (lt_cnt)
    );

    assign range_cnt = le_cnt - lt_cnt;

    always_comb
    begin
        occ_next = occ_reg;
        if (acc)
        begin
            case (req.action)
                ACT_CLEAR: occ_next = '0;
                ACT_LOAD:  occ_next = full ? occ_reg : occ_reg + CW'(1);
                default:   occ_next = occ_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            occ_reg       <= '0;
            pend_reg      <= 1'b0;
            pend_data_reg <= '0;
            rsp_valid_reg <= 1'b0;
            rsp_data_reg  <= '0;
        end
        else
        begin
            occ_reg <= occ_next;

            if (out_load)
            begin
                rsp_valid_reg <= 1'b1;
                rsp_data_reg  <= pend_data_reg;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (acc && (req.action == ACT_QUERY))
                    begin
                        state_reg <= S_CMP;
                        pend_reg  <= 1'b0;
                    end
                    else if (acc)
                    begin
                        pend_reg               <= 1'b1;
                        pend_data_reg.count    <= COUNT_W'(occ_next);
                        pend_data_reg.rejected <= (req.action == ACT_LOAD) && full;
                    end
                    else if (out_load)
                    begin
                        pend_reg <= 1'b0;
                    end
                end
                S_CMP:
                begin
                    state_reg              <= S_IDLE;
                    pend_reg               <= 1'b1;
                    pend_data_reg.count    <= COUNT_W'(range_cnt);
                    pend_data_reg.rejected <= 1'b0;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_data_reg;

    `SSRC_ASSERT_IMP(a_occ_bound, 1'b1, occ_reg <= CW'(DEPTH), "store count beyond depth")
    `SSRC_ASSERT_NXT(a_load_grow, ctl.ins, occ_reg == $past(occ_reg) + CW'(1), "load did not grow store")
    `SSRC_ASSERT_NXT(a_query_cmp, ctl.cap, state_reg == S_CMP && !req_ready, "query did not enter compare")
    `SSRC_ASSERT_NXT(a_pend_hold, pend_reg && rsp_valid && !rsp_ready, pend_reg, "pending result lost")

endmodule

// ----- hw/rtl/ssrc_cell.sv -----
// One cell of the sorted row: holds one entry, shifts right on insert, flags range hits.
// Depends on ssrc_pkg.
`timescale 1ns / 1ps

module ssrc_cell #(
    parameter int IDX = 0,
    parameter int CW  = 7
) (
    input  logic                              clk,
    input  ssrc_pkg::cell_ctl_t               ctl,
    input  logic [CW-1:0]                     occ,
    input  logic signed [ssrc_pkg::DATA_W-1:0] key,
    input  logic signed [ssrc_pkg::DATA_W-1:0] lo,
    input  logic signed [ssrc_pkg::DATA_W-1:0] left_value,
    input  logic                              left_gt,
    output logic signed [ssrc_pkg::DATA_W-1:0] value,
    output logic                              gt,
    output logic                              le_flag,
    output logic                              lt_flag
);
    import ssrc_pkg::*;

    localparam logic [CW-1:0] IDX_C = CW'(IDX);

    logic signed [DATA_W-1:0] value_reg;
    logic                     le_flag_reg;
    logic                     lt_flag_reg;
    logic                     held;
    logic                     le;
    logic                     lt;
    logic                     write;

    assign held  = IDX_C < occ;
    assign le    = value_reg <= key;
    assign lt    = value_reg < lo;
    assign gt    = held && !le;
    assign write = ctl.ins && (gt || (IDX_C == occ));

    always_ff @(posedge clk)
    begin
        if (write)
        begin
            value_reg <= left_gt ? left_value : key;
        end
        if (ctl.cap)
        begin
            le_flag_reg <= held && le;
            lt_flag_reg <= held && lt;
        end
    end

    assign value   = value_reg;
    assign le_flag = le_flag_reg;
    assign lt_flag = lt_flag_reg;

endmodule

// ----- hw/rtl/ssrc_thermo.sv -----
// Thermometer-to-count encoder over the hit flags of the cell row.
// Depends on nothing beyond its parameters.
`timescale 1ns / 1ps

module ssrc_thermo #(
    parameter int N  = 64,
    parameter int CW = 7
) (
    input  logic [N-1:0]  therm,
    output logic [CW-1:0] cnt
);
    logic [N:0]   ext;
    logic [N-1:0] rise;

    assign ext = {1'b0, therm};

    always_comb
    begin
        cnt = '0;
        for (int i = 0; i < N; i++)
        begin
            rise[i] = ext[i] && !ext[i+1];
            if (rise[i])
            begin
                cnt = cnt | CW'(i + 1);
            end
        end
    end

endmodule

// ----- tb/sv/range_count_checker.sv -----
// Checker for the sorted store with range count: watches both channels,
// predicts each response from its own sorted copy of the store and compares.
// Depends on ssrc_pkg.
`timescale 1ns / 1ps

module range_count_checker #(
    parameter int STORE_DEPTH = 64
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    input  logic           req_ready,
    input  ssrc_pkg::req_t req,
    input  logic           rsp_valid,
    input  logic           rsp_ready,
    input  ssrc_pkg::rsp_t rsp,
    output int             mismatches,
    output int             waiting,
    output int             full_drops
);

    import ssrc_pkg::*;

    logic signed [DATA_W-1:0] held_values[$];
    rsp_t                     expected_rsp_q[$];
    int                       fail_count = 0;
    int                       drop_count = 0;

    function automatic rsp_t predict_response(input req_t beat);
        rsp_t                     r;
        int                       pos;
        int                       n;
        logic signed [DATA_W-1:0] a;
        logic signed [DATA_W-1:0] b;
        logic signed [DATA_W-1:0] lo;
        logic signed [DATA_W-1:0] hi;
        logic signed [DATA_W-1:0] v;
        r = '0;
        case (action_t'(beat.action))
            ACT_CLEAR: begin
                held_values.delete();
                r.count = '0;
            end
            ACT_LOAD: begin
                if (held_values.size() >= STORE_DEPTH) begin
                    r.rejected = 1'b1;
                end else begin
                    v   = beat.load_value;
                    pos = 0;
                    foreach (held_values[i])
                        if (held_values[i] <= v)
                            pos = i + 1;
                    held_values.insert(pos, v);
                end
                r.count = COUNT_W'(held_values.size());
            end
            ACT_QUERY: begin
                a  = beat.bound_a;
                b  = beat.bound_b;
                lo = (a < b) ? a : b;
                hi = (a < b) ? b : a;
                n  = 0;
                foreach (held_values[i])
                    if (held_values[i] >= lo && held_values[i] <= hi)
                        n++;
                r.count = COUNT_W'(n);
            end
            default: r.count = COUNT_W'(held_values.size());
        endcase
        return r;
    endfunction

    always @(posedge clk) begin
        rsp_t want;
        if (rst_n) begin
            if (req_valid && req_ready) begin
                want = predict_response(req);
                if (want.rejected)
                    drop_count++;
                expected_rsp_q.push_back(want);
            end
            if (rsp_valid && rsp_ready) begin
                if (expected_rsp_q.size() == 0) begin
                    $error("response beat with nothing expected: count %0d, rejected %0d",
                           rsp.count, rsp.rejected);
                    fail_count++;
                end else begin
                    want = expected_rsp_q.pop_front();
                    if (rsp.count !== want.count) begin
                        $error("count mismatch: expected %0d, got %0d", want.count, rsp.count);
                        fail_count++;
                    end
                    if (rsp.rejected !== want.rejected) begin
                        $error("rejected mismatch: expected %0d, got %0d",
                               want.rejected, rsp.rejected);
                        fail_count++;
                    end
                end
            end
        end
        mismatches <= fail_count;
        waiting    <= expected_rsp_q.size();
        full_drops <= drop_count;
    end

endmodule

// ----- tb/sv/testbench.sv -----
// Top of the sorted store range count testbench: clock, reset, stimulus and verdict.
// Depends on ssrc_pkg, range_count_checker and the sorted_store_range_count RTL.
`timescale 1ns / 1ps

module testbench;

    import ssrc_pkg::*;

    localparam int                       STORE_DEPTH  = 64;
    localparam int                       TOTAL_BEATS  = 2000;
    localparam int                       CALM_FROM    = 1700;
    localparam int                       QUIET_LIMIT  = 2000;
    localparam int                       DRAIN_CYCLES = 20;
    localparam logic signed [DATA_W-1:0] MIN_VAL      = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] MAX_VAL      = 32'sh7fff_ffff;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    req_t req       = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    rsp_t rsp;
    logic idle_on   = 1'b1;

    int mismatches;
    int waiting;
    int full_drops;
    int beats_sent  = 0;
    int loads_sent  = 0;
    int queries     = 0;
    int clears      = 0;
    int noise_beats = 0;
    int stall_left  = 0;

    logic signed [DATA_W-1:0] recent_vals[$];

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    sorted_store_range_count #(
        .DEPTH(STORE_DEPTH)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req      (req),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp      (rsp)
    );

    range_count_checker #(
        .STORE_DEPTH(STORE_DEPTH)
    ) u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .mismatches(mismatches),
        .waiting   (waiting),
        .full_drops(full_drops)
    );

    // stall the response side in bursts of random length while idle_on is set
    always @(posedge clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_ready  <= 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(0, 6);
            rsp_ready  <= 1'b0;
        end else begin
            rsp_ready <= 1'b1;
        end
    end

    function automatic logic signed [DATA_W-1:0] pick_value();
        logic signed [DATA_W-1:0] v;
        case ($urandom_range(0, 9))
            0:       v = MIN_VAL;
            1:       v = MAX_VAL;
            2, 3:    v = int'($urandom_range(0, 16)) - 8;
            4, 5:    v = (recent_vals.size() > 0) ?
                         recent_vals[$urandom_range(0, recent_vals.size() - 1)] : $urandom;
            default: v = $urandom;
        endcase
        return v;
    endfunction

    function automatic req_t scrambled_beat(input action_t act);
        req_t r;
        r.action     = act;
        r.load_value = $urandom;
        r.bound_a    = $urandom;
        r.bound_b    = $urandom;
        return r;
    endfunction

    task automatic send_beat(input req_t beat);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            if (req_valid)
                req_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= beat;
        @(posedge clk);
        while (!req_ready) @(posedge clk);
        beats_sent++;
    endtask

    task automatic clear_store();
        send_beat(scrambled_beat(ACT_CLEAR));
        clears++;
    endtask

    task automatic load_value(input logic signed [DATA_W-1:0] v);
        req_t r;
        r            = scrambled_beat(ACT_LOAD);
        r.load_value = v;
        send_beat(r);
        loads_sent++;
        recent_vals.push_back(v);
        if (recent_vals.size() > 32)
            void'(recent_vals.pop_front());
    endtask

    task automatic range_query(input logic signed [DATA_W-1:0] a,
                               input logic signed [DATA_W-1:0] b);
        req_t r;
        r         = scrambled_beat(ACT_QUERY);
        r.bound_a = a;
        r.bound_b = b;
        send_beat(r);
        queries++;
    endtask

    task automatic unused_code();
        send_beat(scrambled_beat(ACT_NONE));
        noise_beats++;
    endtask

    // hold the sender until every response is back
    task automatic drain_responses();
        req_valid <= 1'b0;
        do @(posedge clk); while (waiting != 0);
    endtask

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge clk);
            if (!rst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("status: fail");
        $finish;
    end

    initial begin : stimulus
        int                       fill;
        int                       loads_done;
        logic signed [DATA_W-1:0] a;
        logic signed [DATA_W-1:0] b;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        range_query(MIN_VAL, MAX_VAL);
        load_value(MIN_VAL);
        load_value(MAX_VAL);
        load_value(0);
        load_value(0);
        load_value(-1);
        load_value(1);
        load_value(MIN_VAL);
        range_query(MIN_VAL, MAX_VAL);
        range_query(MAX_VAL, MIN_VAL);
        range_query(0, 0);
        range_query(MIN_VAL, MIN_VAL);
        range_query(MAX_VAL, MAX_VAL);
        range_query(1, -1);
        range_query(2, 5);
        unused_code();
        range_query(-1, 0);
        clear_store();
        range_query(MIN_VAL, MAX_VAL);
        load_value(32'sd42);
        range_query(32'sd42, 32'sd42);
        drain_responses();

        while (beats_sent < TOTAL_BEATS) begin
            if (beats_sent >= CALM_FROM)
                idle_on <= 1'b0;
            else
                idle_on <= ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 7) != 0)
                clear_store();
            fill       = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 72)
                                                     : $urandom_range(0, 40);
            loads_done = 0;
            while (loads_done < fill) begin
                case ($urandom_range(0, 19))
                    0: unused_code();
                    1, 2, 3, 4, 5: begin
                        a = pick_value();
                        b = ($urandom_range(0, 7) == 0) ? a : pick_value();
                        range_query(a, b);
                    end
                    default: begin
                        load_value(pick_value());
                        loads_done++;
                    end
                endcase
            end
            repeat ($urandom_range(1, 6)) begin
                a = pick_value();
                b = ($urandom_range(0, 7) == 0) ? a : pick_value();
                range_query(a, b);
            end
            if (beats_sent < CALM_FROM && $urandom_range(0, 9) == 0)
                drain_responses();
        end

        req_valid <= 1'b0;
        do @(posedge clk); while (waiting != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d beats: %0d loads (%0d dropped on a full store), %0d range queries,",
                 beats_sent, loads_sent, full_drops, queries);
        $display("  %0d clears and %0d beats with the unused action code", clears, noise_beats);
        if (mismatches == 0 && waiting == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/ssrc_pkg.sv
hw/rtl/ssrc_cell.sv
hw/rtl/ssrc_thermo.sv
hw/rtl/sorted_store_range_count.sv
tb/sv/range_count_checker.sv
tb/sv/testbench.sv
